// File: rtl/core/assert_macros.svh
// Assertion helpers, clocked on clk with rst_n low disabling the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define DPLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When cond holds, prop holds at the next edge.
`define DPLM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/core/dplm_pkg.sv
package dplm_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_PREFIX        = 4;
    localparam int KEY_CHARS         = 4;
    localparam int KEY_W             = 8 * KEY_CHARS;
    localparam int LEN_W             = 3;
    localparam int LOCALE_W          = 16;
    localparam int SPLIT_TOP         = (MAX_PREFIX < KEY_CHARS) ? MAX_PREFIX : KEY_CHARS;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SPLIT  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUP       = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [LEN_W-1:0]    len;
        logic [LOCALE_W-1:0] locale;
    } entry_t;

    // Keeps the first n characters (top bytes) of a key.
    function automatic logic [KEY_W-1:0] char_mask(input logic [LEN_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_CHARS; b++)
        begin
            if (b < int'(n))
            begin
                m[KEY_W-1-8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/core/dial_prefix_longest_match_table_unit.sv
// A request is answered after a scan over the stored entries (at most TABLE_ENTRIES);
// no new request is taken until its response is registered. The pace is set by the single
// read port of the table memory, which is scanned one entry per cycle.
// Reset: the table is empty after reset (fill count cleared); no clearing pass is needed.
// A response may wait on m_tready in its output register while the next scan runs.
module dial_prefix_longest_match_table_unit #(
    parameter int TABLE_ENTRIES = dplm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // key_chars[31:0], key_length[34:32], locale_code[50:35]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // prefix_length[2:0], national[3]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int KW = dplm_pkg::KEY_W;
    localparam int LW = dplm_pkg::LEN_W;

    dplm_pkg::state_t  state_reg, state_next;

    logic [1:0]        op_reg;
    logic [KW-1:0]     key_reg;
    logic [KW-1:0]     qkey_reg;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     lim_reg;
    logic [15:0]       locale_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     addr_reg;
    logic              cmp_valid_reg;
    logic              found_reg;
    logic [LW-1:0]     best_reg;
    logic              natz_reg;

    logic              out_valid_reg;
    dplm_pkg::status_t out_status_reg;
    logic [LW-1:0]     out_plen_reg;
    logic              out_nat_reg;

    logic              accept;
    logic              scan_done;
    logic              issue;
    logic              fin_go;
    logic              wr_en;
    dplm_pkg::status_t res_status;
    logic [LW-1:0]     res_plen;
    logic              res_nat;

    logic [LW-1:0]     in_len;
    logic [LW-1:0]     in_len_sat;
    logic [LW-1:0]     in_lim;

    dplm_pkg::entry_t  wr_data;
    dplm_pkg::entry_t  rd_data;
    logic              hit_exact;
    logic              hit_split;

    dplm_table_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign in_len     = s_tdata[34:32];
    assign in_len_sat = (in_len > LW'(dplm_pkg::KEY_CHARS)) ? LW'(dplm_pkg::KEY_CHARS) : in_len;
    assign in_lim     = (in_len_sat < LW'(dplm_pkg::SPLIT_TOP)) ? in_len_sat
                                                                : LW'(dplm_pkg::SPLIT_TOP);

    assign accept    = s_tvalid && s_tready;
    assign scan_done = (addr_reg == count_reg);

    assign wr_data.key    = qkey_reg;
    assign wr_data.len    = len_reg;
    assign wr_data.locale = locale_reg;

    // exact key for insert/query; for split, any stored prefix of the number up to the limit,
    // the empty prefix only when the number is empty
    assign hit_exact = (rd_data.len == len_reg) && (rd_data.key == qkey_reg);
    assign hit_split = ((rd_data.len != '0) || (lim_reg == '0)) && (rd_data.len <= lim_reg)
                       && (rd_data.key == (key_reg & dplm_pkg::char_mask(rd_data.len)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dplm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = dplm_pkg::S_SCAN;
                end
            end
            dplm_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = dplm_pkg::S_FIN;
                end
            end
            dplm_pkg::S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = dplm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dplm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        issue      = 1'b0;
        fin_go     = 1'b0;
        wr_en      = 1'b0;
        res_status = dplm_pkg::ST_NOT_FOUND;
        res_plen   = '0;
        res_nat    = 1'b0;
        unique case (state_reg)
            dplm_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            dplm_pkg::S_SCAN:
            begin
                issue = !scan_done;
            end
            dplm_pkg::S_FIN:
            begin
                fin_go = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase

        case (op_reg)
            dplm_pkg::OP_INSERT:
            begin
                if (found_reg)
                begin
                    res_status = dplm_pkg::ST_DUP;
                end
                else if (count_reg < CW'(TABLE_ENTRIES))
                begin
                    res_status = dplm_pkg::ST_OK;
                    wr_en      = fin_go;
                end
                else
                begin
                    res_status = dplm_pkg::ST_FULL;
                end
            end
            dplm_pkg::OP_SPLIT:
            begin
                if (found_reg)
                begin
                    res_status = dplm_pkg::ST_OK;
                    res_plen   = best_reg;
                end
            end
            dplm_pkg::OP_QUERY:
            begin
                if (found_reg)
                begin
                    res_status = dplm_pkg::ST_OK;
                    res_nat    = natz_reg;
                end
                else
                begin
                    res_nat = 1'b1;
                end
            end
            default:
            begin
                res_status = dplm_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dplm_pkg::S_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= issue;
            if (accept)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (issue)
            begin
                addr_reg <= addr_reg + CW'(1);
            end
            if (cmp_valid_reg)
            begin
                if (op_reg == dplm_pkg::OP_SPLIT)
                begin
                    if (hit_split)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                else if (hit_exact)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            key_reg    <= s_tdata[31:0];
            qkey_reg   <= s_tdata[31:0] & dplm_pkg::char_mask(in_len_sat);
            len_reg    <= in_len_sat;
            lim_reg    <= in_lim;
            locale_reg <= s_tdata[50:35];
            best_reg   <= '0;
            natz_reg   <= 1'b0;
        end
        if (cmp_valid_reg)
        begin
            if (op_reg == dplm_pkg::OP_SPLIT)
            begin
                if (hit_split && (rd_data.len > best_reg))
                begin
                    best_reg <= rd_data.len;
                end
            end
            else if (hit_exact)
            begin
                natz_reg <= (rd_data.locale == '0);
            end
        end
        if (fin_go)
        begin
            out_status_reg <= res_status;
            out_plen_reg   <= res_plen;
            out_nat_reg    <= res_nat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_nat_reg, out_plen_reg};
    assign m_tuser  = out_status_reg;

endmodule

// File: rtl/core/dplm_table_ram.sv
module dplm_table_ram #(
    parameter int DEPTH = dplm_pkg::TABLE_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  dplm_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output dplm_pkg::entry_t  rd_data
);

    dplm_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/dplm_checker.sv
`include "assert_macros.svh"

module dplm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    `DPLM_ASSERT_NEXT(a_resp_hold, m_tvalid && !m_tready, m_tvalid, "response dropped while stalled")
    `DPLM_ASSERT_NEXT(a_resp_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled response changed")
    `DPLM_ASSERT(a_plen_range, !m_tvalid || (m_tdata[2:0] <= 3'd4), "prefix length above four")
    `DPLM_ASSERT(a_plen_ok, !m_tvalid || (m_tdata[2:0] == 3'd0) || (m_tuser == dplm_pkg::ST_OK), "prefix length without ok status")
    `DPLM_ASSERT(a_nat_status, !m_tvalid || !m_tdata[3] || (m_tuser == dplm_pkg::ST_OK) || (m_tuser == dplm_pkg::ST_NOT_FOUND), "national flag on insert status")

endmodule

bind dial_prefix_longest_match_table_unit dplm_checker u_dplm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
